// ===== src/vietnamese_legacy_charset_encoder_top_macros.svh =====
// Assertion macros for the encoder modules (included by the back end).
`ifndef VIETNAMESE_LEGACY_CHARSET_ENCODER_TOP_MACROS_SVH
`define VIETNAMESE_LEGACY_CHARSET_ENCODER_TOP_MACROS_SVH

// Condition that holds on every enabled edge.
`define LVCE_ASSERT_NOW(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent on the same edge.
`define LVCE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent on the next edge.
`define LVCE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lvce_pkg.sv =====
// Types, constants and glyph table for the Vietnamese legacy charset encoder.
package lvce_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int RUN_BYTES   = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       text_done;
   } rsp_type;

   // Output bytes caused by one input transaction.
   typedef struct packed {
      logic [RUN_BYTES-1:0][7:0] bytes;
      logic [2:0]                count;
      logic                      eot;
   } run_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] tcvn;
      logic [7:0] vni1;
      logic [7:0] vni2;
   } glyph_type;

   function automatic run_type run_put_byte(run_type r, logic [7:0] b);
      run_type t;
      t = r;
      if (t.count < 3'(RUN_BYTES)) begin
         t.bytes[t.count[1:0]] = b;
         t.count = t.count + 3'd1;
      end
      return t;
   endfunction

   // Latin-1 glyph written out as UTF-8.
   function automatic run_type run_put_glyph(run_type r, logic [7:0] c);
      run_type t;
      t = r;
      if (!c[7]) begin
         t = run_put_byte(t, c);
      end else begin
         t = run_put_byte(t, {6'b110000, c[7:6]});
         t = run_put_byte(t, {2'b10, c[5:0]});
      end
      return t;
   endfunction

   function automatic glyph_type glyph_lookup(logic [15:0] cp);
      glyph_type g;
      g = '{1'b0, 8'h00, 8'h00, 8'h00};
      unique case (cp)
         16'h0103: g = '{1'b1, 8'hA8, 8'h61, 8'hEA};
         16'h00E2: g = '{1'b1, 8'hA9, 8'h61, 8'hE2};
         16'h0111: g = '{1'b1, 8'hAE, 8'hF1, 8'h00};
         16'h00EA: g = '{1'b1, 8'hAA, 8'h65, 8'hE2};
         16'h00F4: g = '{1'b1, 8'hAB, 8'h6F, 8'hE2};
         16'h01A1: g = '{1'b1, 8'hAC, 8'hF4, 8'h00};
         16'h01B0: g = '{1'b1, 8'hAD, 8'hF6, 8'h00};
         16'h00E1: g = '{1'b1, 8'hB8, 8'h61, 8'hF9};
         16'h00E0: g = '{1'b1, 8'hB5, 8'h61, 8'hF8};
         16'h1EA3: g = '{1'b1, 8'hB6, 8'h61, 8'hFB};
         16'h00E3: g = '{1'b1, 8'hB7, 8'h61, 8'hF5};
         16'h1EA1: g = '{1'b1, 8'hB9, 8'h61, 8'hEF};
         16'h1EAF: g = '{1'b1, 8'hBE, 8'h61, 8'hE9};
         16'h1EB1: g = '{1'b1, 8'hBB, 8'h61, 8'hE8};
         16'h1EB3: g = '{1'b1, 8'hBC, 8'h61, 8'hFA};
         16'h1EB5: g = '{1'b1, 8'hBD, 8'h61, 8'hFC};
         16'h1EB7: g = '{1'b1, 8'hC6, 8'h61, 8'hEB};
         16'h1EA5: g = '{1'b1, 8'hCA, 8'h61, 8'hE1};
         16'h1EA7: g = '{1'b1, 8'hC7, 8'h61, 8'hE0};
         16'h1EA9: g = '{1'b1, 8'hC8, 8'h61, 8'hE5};
         16'h1EAB: g = '{1'b1, 8'hC9, 8'h61, 8'hE3};
         16'h1EAD: g = '{1'b1, 8'hCB, 8'h61, 8'hE4};
         16'h00E9: g = '{1'b1, 8'hD0, 8'h65, 8'hF9};
         16'h00E8: g = '{1'b1, 8'hCC, 8'h65, 8'hF8};
         16'h1EBB: g = '{1'b1, 8'hCE, 8'h65, 8'hFB};
         16'h1EBD: g = '{1'b1, 8'hCF, 8'h65, 8'hF5};
         16'h1EB9: g = '{1'b1, 8'hD1, 8'h65, 8'hEF};
         16'h1EBF: g = '{1'b1, 8'hD5, 8'h65, 8'hE1};
         16'h1EC1: g = '{1'b1, 8'hD2, 8'h65, 8'hE0};
         16'h1EC3: g = '{1'b1, 8'hD3, 8'h65, 8'hE5};
         16'h1EC5: g = '{1'b1, 8'hD4, 8'h65, 8'hE3};
         16'h1EC7: g = '{1'b1, 8'hD6, 8'h65, 8'hE4};
         16'h00ED: g = '{1'b1, 8'hDD, 8'hED, 8'h00};
         16'h00EC: g = '{1'b1, 8'hD7, 8'hEC, 8'h00};
         16'h1EC9: g = '{1'b1, 8'hD8, 8'hE6, 8'h00};
         16'h0129: g = '{1'b1, 8'hDC, 8'hF3, 8'h00};
         16'h1ECB: g = '{1'b1, 8'hDE, 8'hF2, 8'h00};
         16'h00F3: g = '{1'b1, 8'hE3, 8'h6F, 8'hF9};
         16'h00F2: g = '{1'b1, 8'hDF, 8'h6F, 8'hF8};
         16'h1ECF: g = '{1'b1, 8'hE1, 8'h6F, 8'hFB};
         16'h00F5: g = '{1'b1, 8'hE2, 8'h6F, 8'hF5};
         16'h1ECD: g = '{1'b1, 8'hE4, 8'h6F, 8'hEF};
         16'h1ED1: g = '{1'b1, 8'hE8, 8'h6F, 8'hE1};
         16'h1ED3: g = '{1'b1, 8'hE5, 8'h6F, 8'hE0};
         16'h1ED5: g = '{1'b1, 8'hE6, 8'h6F, 8'hE5};
         16'h1ED7: g = '{1'b1, 8'hE7, 8'h6F, 8'hE3};
         16'h1ED9: g = '{1'b1, 8'hE9, 8'h6F, 8'hE4};
         16'h1EDB: g = '{1'b1, 8'hED, 8'hF4, 8'hF9};
         16'h1EDD: g = '{1'b1, 8'hEA, 8'hF4, 8'hF8};
         16'h1EDF: g = '{1'b1, 8'hEB, 8'hF4, 8'hFB};
         16'h1EE1: g = '{1'b1, 8'hEC, 8'hF4, 8'hF5};
         16'h1EE3: g = '{1'b1, 8'hEE, 8'hF4, 8'hEF};
         16'h00FA: g = '{1'b1, 8'hF3, 8'h75, 8'hF9};
         16'h00F9: g = '{1'b1, 8'hEF, 8'h75, 8'hF8};
         16'h1EE7: g = '{1'b1, 8'hF1, 8'h75, 8'hFB};
         16'h0169: g = '{1'b1, 8'hF2, 8'h75, 8'hF5};
         16'h1EE5: g = '{1'b1, 8'hF4, 8'h75, 8'hEF};
         16'h1EE9: g = '{1'b1, 8'hF8, 8'hF6, 8'hF9};
         16'h1EEB: g = '{1'b1, 8'hF5, 8'hF6, 8'hF8};
         16'h1EED: g = '{1'b1, 8'hF6, 8'hF6, 8'hFB};
         16'h1EEF: g = '{1'b1, 8'hF7, 8'hF6, 8'hF5};
         16'h1EF1: g = '{1'b1, 8'hF9, 8'hF6, 8'hEF};
         16'h00FD: g = '{1'b1, 8'hFD, 8'h79, 8'hF9};
         16'h1EF3: g = '{1'b1, 8'hFA, 8'h79, 8'hF8};
         16'h1EF7: g = '{1'b1, 8'hFB, 8'h79, 8'hFB};
         16'h1EF9: g = '{1'b1, 8'hFC, 8'h79, 8'hF5};
         16'h1EF5: g = '{1'b1, 8'hFE, 8'hEE, 8'h00};
         default:  g = '{1'b0, 8'h00, 8'h00, 8'h00};
      endcase
      return g;
   endfunction

endpackage

// ===== src/lvce_front.sv =====
// Front end: UTF-8 sequence assembly, glyph lookup and run building.
module lvce_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_wdata,
   input  logic              push,
   input  lvce_pkg::req_type req_data,
   input  logic              q_full,
   output logic              q_push,
   output lvce_pkg::run_type q_data
);
   import lvce_pkg::*;

   logic       target_ff;
   logic [1:0] pcount_ff, pcount_in;
   logic [1:0] elen_ff, elen_in;
   logic [7:0] pend0_ff, pend0_in;
   logic [7:0] pend1_ff, pend1_in;
   logic       accept;
   run_type    run;

   assign accept = push && !q_full;
   assign q_push = accept && (run.count != 3'd0);
   assign q_data = run;

   always_comb begin
      logic [7:0]  b;
      logic        handled;
      logic [15:0] cp;
      logic        wide_ok;
      glyph_type   g;
      b         = req_data.in_byte;
      handled   = 1'b0;
      cp        = '0;
      wide_ok   = 1'b0;
      g         = '{1'b0, 8'h00, 8'h00, 8'h00};
      run       = '{bytes: '0, count: 3'd0, eot: req_data.end_of_text};
      pcount_in = pcount_ff;
      elen_in   = elen_ff;
      pend0_in  = pend0_ff;
      pend1_in  = pend1_ff;

      if (pcount_ff != 2'd0) begin
         if (b[7:6] == 2'b10) begin
            handled = 1'b1;
            if (({1'b0, pcount_ff} + 3'd1) >= {1'b0, elen_ff}) begin
               if (elen_ff == 2'd2) begin
                  cp      = {5'b0, pend0_ff[4:0], b[5:0]};
                  wide_ok = (pend0_ff[4:1] != 4'd0);
               end else begin
                  cp      = {pend0_ff[3:0], pend1_ff[5:0], b[5:0]};
                  wide_ok = (cp[15:11] != 5'd0);
               end
               g         = glyph_lookup(cp);
               pcount_in = 2'd0;
               elen_in   = 2'd0;
               if (wide_ok && g.hit) begin
                  if (!target_ff) begin
                     run = run_put_glyph(run, g.tcvn);
                  end else begin
                     run = run_put_glyph(run, g.vni1);
                     if (g.vni2 != 8'h00) run = run_put_glyph(run, g.vni2);
                  end
               end else begin
                  run = run_put_byte(run, pend0_ff);
                  if (pcount_ff == 2'd2) run = run_put_byte(run, pend1_ff);
                  run = run_put_byte(run, b);
               end
            end else begin
               pend1_in  = b;
               pcount_in = 2'd2;
            end
         end else begin
            run = run_put_byte(run, pend0_ff);
            if (pcount_ff == 2'd2) run = run_put_byte(run, pend1_ff);
            pcount_in = 2'd0;
            elen_in   = 2'd0;
         end
      end

      if (!handled) begin
         if (b >= 8'hC0 && b <= 8'hEF) begin
            pend0_in  = b;
            pcount_in = 2'd1;
            elen_in   = b[5] ? 2'd3 : 2'd2;
         end else begin
            run = run_put_byte(run, b);
         end
      end

      if (req_data.end_of_text) begin
         if (pcount_in != 2'd0) run = run_put_byte(run, pend0_in);
         if (pcount_in == 2'd2) run = run_put_byte(run, pend1_in);
         pcount_in = 2'd0;
         elen_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= 1'b0;
         pcount_ff <= 2'd0;
         elen_ff   <= 2'd0;
      end else begin
         if (csr_we) target_ff <= csr_wdata;
         if (accept) begin
            pcount_ff <= pcount_in;
            elen_ff   <= elen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend0_ff <= pend0_in;
         pend1_ff <= pend1_in;
      end
   end

endmodule

// ===== src/lvce_queue.sv =====
// Short run queue between the front end and the byte serialiser.
module lvce_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  lvce_pkg::run_type wr_data,
   input  logic              rd_en,
   output lvce_pkg::run_type rd_data,
   output logic              full,
   output logic              empty
);
   import lvce_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   run_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wptr_ff, rptr_ff;
   logic [CNT_W-1:0]       count_ff;
   logic                   do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entry_ff[rptr_ff];

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(logic [QUEUE_PTR_W-1:0] p);
      logic [QUEUE_PTR_W-1:0] n;
      n = (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
      return n;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_wr) wptr_ff <= ptr_next(wptr_ff);
         if (do_rd) rptr_ff <= ptr_next(rptr_ff);
         if (do_wr && !do_rd) count_ff <= count_ff + 1'b1;
         else if (do_rd && !do_wr) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) entry_ff[wptr_ff] <= wr_data;
   end

endmodule

// ===== src/lvce_back.sv =====
// Back end: serialises each run into output bytes with run and text flags.
`include "vietnamese_legacy_charset_encoder_top_macros.svh"

module lvce_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  lvce_pkg::run_type q_data,
   output logic              q_pop,
   input  logic              pop,
   output logic              empty,
   output lvce_pkg::rsp_type rsp_data
);
   import lvce_pkg::*;

   run_type    run_ff, run_in;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       last;
   logic       advance;

   assign last    = ({1'b0, idx_ff} == (run_ff.count - 3'd1));
   assign advance = !valid_ff || (pop && last);
   assign q_pop   = advance && !q_empty;
   assign empty   = !valid_ff;

   assign rsp_data.out_byte    = run_ff.bytes[idx_ff];
   assign rsp_data.last_of_run = last;
   assign rsp_data.text_done   = last && run_ff.eot;

   always_comb begin
      run_in   = run_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      priority if (q_pop) begin
         run_in   = q_data;
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (advance) begin
         valid_in = 1'b0;
      end else if (pop) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

   `LVCE_ASSERT_IMP(a_idx_in_run, clock, reset, valid_ff, ({1'b0, idx_ff} < run_ff.count), "byte index beyond run")
   `LVCE_ASSERT_IMP(a_done_is_last, clock, reset, (valid_ff && rsp_data.text_done), rsp_data.last_of_run, "text_done off last byte")
   `LVCE_ASSERT_NXT(a_mid_run_holds, clock, reset, (valid_ff && pop && !last), (valid_ff && idx_ff != 2'd0), "run dropped")
   `LVCE_ASSERT_IMP(a_pop_nonempty, clock, reset, q_pop, !q_empty, "queue popped while empty")

endmodule

// ===== src/vietnamese_legacy_charset_encoder_top.sv =====
// Top level of the UTF-8 to TCVN3 / VNI Vietnamese transcoder.
// One input byte is taken per cycle while the run queue has room; an input that
// only extends a pending UTF-8 sequence produces nothing. Each completed input
// produces a run of 1 to 4 output bytes that the serialiser hands out one per
// cycle while pop is held, so the output bytes set the sustained rate: an input
// weighs as many output bytes as it produces (one for plain ASCII, up to four for
// a VNI two-glyph letter). A two-run queue decouples input acceptance from output
// back-pressure. csr_wdata selects TCVN3 (0) or VNI (1); write it while idle.
module vietnamese_legacy_charset_encoder_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_wdata,
   input  logic              push,
   output logic              full,
   input  lvce_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output lvce_pkg::rsp_type rsp_data
);
   import lvce_pkg::*;

   logic    q_push, q_pop, q_full, q_empty;
   run_type q_wdata, q_rdata;

   assign full = q_full;

   lvce_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .push      (push),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   lvce_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wdata),
      .rd_en   (q_pop),
      .rd_data (q_rdata),
      .full    (q_full),
      .empty   (q_empty)
   );

   lvce_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_rdata),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

endmodule
